// ===== src/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CpW        = 21;
  localparam int unsigned CntW       = 2;   // width of cnt_m1, the count of results per item minus one
  localparam int unsigned QueueDepth = 2;

  localparam logic [CpW-1:0] ReplacementCp = 21'h00FFFD;

  // one decoded job: cnt_m1 replacement results come first, then the final one
  typedef struct packed {
    logic [CntW-1:0] cnt_m1;
    logic [CpW-1:0]  code_point;
    logic            replaced;
  } job_t;

endpackage

// ===== src/utf8d_front.sv =====
// ----------------------------------------------------------------------------
// utf8d_front
// accepts text bytes, tracks the pending form and turns each item that gives results into a job
// ----------------------------------------------------------------------------
module utf8d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [utf8d_pkg::ByteW-1:0]   byte_value_i,
  input  logic                          end_of_text_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output utf8d_pkg::job_t               q_job_o
);
  import utf8d_pkg::*;

  logic             lead_held_q, lead_held_d;
  logic [ByteW-1:0] pending_lead_q, pending_lead_d;
  logic [1:0]       held_count_q, held_count_d;
  logic [ByteW-1:0] held_cont_q [2];

  logic             accept;
  logic             is_cont, is_lead, hold_cont;
  logic [1:0]       need;
  logic [2:0]       n_res;
  logic [2:0]       flush_n;
  logic             has_final;
  logic [CpW-1:0]   final_cp;
  logic             final_rep;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_cont = (byte_value_i[7:6] == 2'b10);
  assign is_lead = (byte_value_i[7:5] == 3'b110) || (byte_value_i[7:4] == 4'b1110)
                || (byte_value_i[7:3] == 5'b11110);

  always_comb begin
    if (pending_lead_q[7:5] == 3'b110) begin
      need = 2'd1;
    end else if (pending_lead_q[7:4] == 4'b1110) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
  end

  always_comb begin
    lead_held_d    = lead_held_q;
    pending_lead_d = pending_lead_q;
    held_count_d   = held_count_q;
    hold_cont      = 1'b0;
    has_final      = 1'b0;
    final_cp       = ReplacementCp;
    final_rep      = 1'b1;
    flush_n        = 3'd0;
    if (lead_held_q && is_cont) begin
      if ({1'b0, held_count_q} + 3'd1 >= {1'b0, need}) begin
        // form complete
        has_final = 1'b1;
        final_rep = 1'b0;
        unique case (need)
          2'd1: final_cp = {10'd0, pending_lead_q[4:0], byte_value_i[5:0]};
          2'd2: final_cp = {5'd0, pending_lead_q[3:0], held_cont_q[0][5:0],
                            byte_value_i[5:0]};
          default: final_cp = {pending_lead_q[2:0], held_cont_q[0][5:0],
                               held_cont_q[1][5:0], byte_value_i[5:0]};
        endcase
        lead_held_d  = 1'b0;
        pending_lead_d = '0;
        held_count_d = 2'd0;
      end else if (end_of_text_i) begin
        // text ends inside the form: lead, held bytes and this byte all replaced
        flush_n   = {1'b0, held_count_q} + 3'd1;
        has_final = 1'b1;
      end else begin
        hold_cont    = 1'b1;
        held_count_d = held_count_q + 2'd1;
      end
    end else begin
      if (lead_held_q) begin
        flush_n = {1'b0, held_count_q} + 3'd1;
      end
      lead_held_d    = 1'b0;
      pending_lead_d = '0;
      held_count_d   = 2'd0;
      if (!byte_value_i[7]) begin
        has_final = 1'b1;
        final_rep = 1'b0;
        final_cp  = {13'd0, byte_value_i};
      end else if (is_lead && !end_of_text_i) begin
        lead_held_d    = 1'b1;
        pending_lead_d = byte_value_i;
      end else begin
        has_final = 1'b1;
      end
    end
    if (end_of_text_i) begin
      lead_held_d    = 1'b0;
      pending_lead_d = '0;
      held_count_d   = 2'd0;
    end
  end

  assign n_res            = flush_n + {2'd0, has_final};
  assign q_push_o         = accept && (n_res != 3'd0);
  assign q_job_o.cnt_m1   = CntW'(n_res - 3'd1);
  assign q_job_o.code_point = final_cp;
  assign q_job_o.replaced = final_rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_held_q    <= 1'b0;
      pending_lead_q <= '0;
      held_count_q   <= 2'd0;
    end else if (accept) begin
      lead_held_q    <= lead_held_d;
      pending_lead_q <= pending_lead_d;
      held_count_q   <= held_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_cont) begin
      held_cont_q[held_count_q[0]] <= byte_value_i;
    end
  end

endmodule

// ===== src/utf8d_queue.sv =====
// ----------------------------------------------------------------------------
// utf8d_queue
// short job queue between the classifying front and the emitting back
// ----------------------------------------------------------------------------
module utf8d_queue #(
  parameter int unsigned Depth = utf8d_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  utf8d_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output utf8d_pkg::job_t head_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntQW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntQW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntQW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== src/utf8d_back.sv =====
// ----------------------------------------------------------------------------
// utf8d_back
// expands each job into its results and holds the output register
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  utf8d_pkg::job_t             q_head_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [utf8d_pkg::CpW-1:0]   code_point_o,
  output logic                        replaced_o,
  output logic                        last_of_run_o
);
  import utf8d_pkg::*;

  job_t            job_q;
  logic            valid_q;
  logic [CntW-1:0] idx_q;
  logic            last;

  assign last          = (idx_q == job_q.cnt_m1);
  assign q_pop_o       = q_valid_i && (!valid_q || (out_ready_i && last));
  assign out_valid_o   = valid_q;
  assign code_point_o  = last ? job_q.code_point : ReplacementCp;
  assign replaced_o    = last ? job_q.replaced : 1'b1;
  assign last_of_run_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_head_i;
    end
  end

endmodule

// ===== src/utf8_decoder_with_replacement.sv =====
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement
// utf-8 byte stream to code point decoder with u+fffd replacement
// ----------------------------------------------------------------------------
// usage
//   input channel: one text byte per item (byte_value_i, end_of_text_i) on
//   in_valid_i / in_ready_o; an item is taken at a clock edge with both high
//   output channel: one code point per item (code_point_o, replaced_o,
//   last_of_run_o) on out_valid_o / out_ready_i
//   each input byte gives zero to four results; last_of_run_o marks the final
//   result of a byte, a byte that only extends a pending form gives none
//   a byte's job goes into the job queue, then into the output register, from
//   which its results are offered
//   throughput: one byte per cycle while each byte gives at most one result
//   and the receiver does not stall; a byte giving several results holds the
//   output side while the back-end expansion counter steps through them
//   reset: the pending form is dropped and the job queue emptied
//   when the receiver stalls the output register holds, the job queue fills
//   and in_ready_o falls only once the queue is full
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement #(
  parameter int unsigned QueueDepth = utf8d_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [utf8d_pkg::ByteW-1:0] byte_value_i,
  input  logic                        end_of_text_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [utf8d_pkg::CpW-1:0]   code_point_o,
  output logic                        replaced_o,
  output logic                        last_of_run_o
);
  import utf8d_pkg::*;

  // front to queue
  logic q_full, q_push;
  job_t q_job;
  // queue to back
  logic q_valid, q_pop;
  job_t q_head;

  // front end: holds lead and continuation bytes, turns each item with results into a job
  utf8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_value_i  (byte_value_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (q_job)
  );

  // decoupling queue, lets either side stall on its own
  utf8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // back end: replacement results first, then the final code point
  utf8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the utf-8 decoder with u+fffd replacement
// ----------------------------------------------------------------------------
// directed run: ascii extremes, every form length, the top code point,
// broken leads, text ending inside a form and stray bytes
// random run: mostly well-formed forms with random content, plus some
// truncated forms, stray bytes and noise
// both sides idle and stall at random in several phases
// the scoreboard decodes every accepted byte itself and compares each
// result, field by field, with the oldest one still awaited
// ----------------------------------------------------------------------------
module testbench;

  import utf8d_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemsPerPhase = 74;

  // one decoded result as the block should give it
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           replaced;
    logic           last_of_run;
  } cp_result_t;

  // decoder model and store of the results still awaited
  class decode_scoreboard;
    cp_result_t awaited_cps[$];
    cp_result_t step_results[$];
    int unsigned fails;

    // decode state: held lead and the continuation bytes seen so far
    bit               lead_held;
    logic [ByteW-1:0] pending_lead;
    logic [ByteW-1:0] held_conts[2];
    int unsigned      held_count;

    function new();
      fails = 0;
      lead_held = 0;
      pending_lead = '0;
      held_conts[0] = '0;
      held_conts[1] = '0;
      held_count = 0;
    endfunction

    function void add_result(logic [CpW-1:0] cp, logic rep);
      cp_result_t r;
      r.code_point = cp;
      r.replaced = rep;
      r.last_of_run = 1'b0;
      step_results = {step_results, r};
    endfunction

    // broken form: one replacement for the lead and one per held byte
    function void flush_broken();
      add_result(ReplacementCp, 1'b1);
      for (int unsigned j = 0; j < held_count; j++) add_result(ReplacementCp, 1'b1);
      lead_held = 0;
      pending_lead = '0;
      held_count = 0;
    endfunction

    // note an accepted byte and queue the results it should cause
    function void note_byte(logic [ByteW-1:0] b, logic eot);
      int unsigned needed;
      logic [CpW-1:0] cp;
      bit is_lead;
      step_results.delete();
      if (lead_held && b[7:6] == 2'b10) begin
        if (pending_lead[7:5] == 3'b110) needed = 1;
        else if (pending_lead[7:4] == 4'b1110) needed = 2;
        else needed = 3;
        if (held_count + 1 >= needed) begin
          case (needed)
            1: cp = CpW'({pending_lead[4:0], b[5:0]});
            2: cp = CpW'({pending_lead[3:0], held_conts[0][5:0], b[5:0]});
            default: cp = CpW'({pending_lead[2:0], held_conts[0][5:0],
                                held_conts[1][5:0], b[5:0]});
          endcase
          add_result(cp, 1'b0);
          lead_held = 0;
          pending_lead = '0;
          held_count = 0;
        end else if (eot) begin
          // text ends inside a form, this continuation is replaced too
          flush_broken();
          add_result(ReplacementCp, 1'b1);
        end else begin
          held_conts[held_count[0]] = b;
          held_count = held_count + 1;
        end
      end else begin
        if (lead_held) flush_broken();
        is_lead = (b[7:5] == 3'b110) || (b[7:4] == 4'b1110) || (b[7:3] == 5'b11110);
        if (!b[7]) add_result(CpW'(b), 1'b0);
        else if (is_lead && eot) add_result(ReplacementCp, 1'b1);
        else if (is_lead) begin
          lead_held = 1;
          pending_lead = b;
          held_count = 0;
        end else add_result(ReplacementCp, 1'b1);
      end
      if (eot) begin
        lead_held = 0;
        pending_lead = '0;
        held_count = 0;
      end
      if (step_results.size() > 0) step_results[$].last_of_run = 1'b1;
      awaited_cps = {awaited_cps, step_results};
    endfunction

    // compare one accepted result with the oldest awaited one
    function void check_result(logic [CpW-1:0] cp, logic rep, logic last);
      cp_result_t exp_r;
      if (awaited_cps.size() == 0) begin
        $error("unexpected result: code_point %h replaced %b last_of_run %b",
               cp, rep, last);
        fails++;
        return;
      end
      exp_r = awaited_cps.pop_front();
      if (cp !== exp_r.code_point) begin
        $error("code_point: expected %h, got %h", exp_r.code_point, cp);
        fails++;
      end
      if (rep !== exp_r.replaced) begin
        $error("replaced: expected %b, got %b", exp_r.replaced, rep);
        fails++;
      end
      if (last !== exp_r.last_of_run) begin
        $error("last_of_run: expected %b, got %b", exp_r.last_of_run, last);
        fails++;
      end
    endfunction
  endclass

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] byte_value_i = '0;
  logic             end_of_text_i = 1'b0;

  // output channel
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [CpW-1:0]   code_point_o;
  logic             replaced_o;
  logic             last_of_run_o;

  // idling odds out of a hundred, changed per phase
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned cycle_count = 0;

  decode_scoreboard sb = new();

  utf8_decoder_with_replacement dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .replaced_o   (replaced_o),
    .last_of_run_o(last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: take the result seen at this edge, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(code_point_o, replaced_o, last_of_run_o);
    end
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // present one byte, with random idle cycles ahead of it, and wait for it
  // to be taken; valid is only lowered when an idle cycle follows
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eot);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, eot);
  endtask

  // random text: mostly whole forms, some cut short, stray bytes and noise
  task automatic send_random_text(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned form_len;
    int unsigned n_conts;
    logic [ByteW-1:0] lead;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_byte(ByteW'($urandom_range(0, 127)), $urandom_range(0, 15) == 0);
        sent++;
      end else if (kind < 85) begin
        form_len = $urandom_range(2, 4);
        case (form_len)
          2: lead = {3'b110, 5'($urandom)};
          3: lead = {4'b1110, 4'($urandom)};
          default: lead = {5'b11110, 3'($urandom)};
        endcase
        // whole form, or a truncated one that the next byte breaks
        n_conts = (kind < 75) ? form_len - 1 : $urandom_range(0, form_len - 2);
        send_byte(lead, $urandom_range(0, 15) == 0);
        sent++;
        for (int unsigned k = 0; k < n_conts; k++) begin
          send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 15) == 0);
          sent++;
        end
      end else if (kind < 92) begin
        // stray continuation or an invalid high byte
        if ($urandom_range(0, 1)) send_byte(ByteW'($urandom_range(8'h80, 8'hBF)), 1'b0);
        else send_byte(ByteW'($urandom_range(8'hF8, 8'hFF)), $urandom_range(0, 15) == 0);
        sent++;
      end else begin
        send_byte(ByteW'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // directed text, end_of_text in the top bit
  logic [ByteW:0] directed_text [26] = '{
    9'h000, 9'h17F,                    // ascii extremes, end on plain byte
    9'h0C2, 9'h0A9,                    // two-byte form
    9'h0E2, 9'h082, 9'h0AC,            // three-byte form
    9'h0F0, 9'h09F, 9'h098, 9'h080,    // four-byte form
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,    // highest code point, lead above f4
    9'h0C2, 9'h041,                    // lead broken by a plain byte
    9'h0F4, 9'h08F, 9'h0BF, 9'h1C3,    // broken with two held, lead at end
    9'h1DF,                            // lead as the last byte
    9'h0E1, 9'h180,                    // text ends inside a form
    9'h080, 9'h0FF                     // stray continuation, invalid byte
  };

  initial begin
    // reset held low at the start, released on a clock edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no idling
    foreach (directed_text[i]) send_byte(directed_text[i][ByteW-1:0], directed_text[i][ByteW]);
    send_random_text(ItemsPerPhase);

    // sender idling
    sender_idle_pct = 52;
    receiver_stall_pct = 0;
    send_random_text(ItemsPerPhase);

    // receiver stalling, the job queue fills up
    sender_idle_pct = 0;
    receiver_stall_pct = 52;
    send_random_text(ItemsPerPhase);

    // both sides
    sender_idle_pct = 33;
    receiver_stall_pct = 33;
    send_random_text(ItemsPerPhase);

    in_valid_i <= 1'b0;
    receiver_stall_pct = 0;

    // drain, then wait on to catch any extra result
    while (sb.awaited_cps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/utf8d_pkg.sv
src/utf8d_front.sv
src/utf8d_queue.sv
src/utf8d_back.sv
src/utf8_decoder_with_replacement.sv
tb/sv/testbench.sv
